// ===== src/kt_pkg.sv =====
// Shared types and constants for the keyed table block.
package kt_pkg;

  localparam int WORD_W      = 64;
  localparam int QTY_W       = 32;
  localparam int SLOT_W      = 4;
  localparam int MAX_RESULTS = 16;
  localparam int NAME_IO     = 4;
  localparam int KIND_IO     = 3;
  localparam int EXT_W       = 8;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_LIST   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RESP,
    ST_LIST
  } state_t;

  // Per-cell update select; at most one bit is set in a cycle
  typedef struct packed {
    logic load;
    logic shift;
    logic wrap;
  } cell_ctl_t;

endpackage

// ===== src/kt_req_if.sv =====
// Request channel: operation and entry payload.
interface kt_req_if
  import kt_pkg::*;
;
  logic              valid;
  logic              ready;
  mode_t             mode;
  logic [WORD_W-1:0] name_w0;
  logic [WORD_W-1:0] name_w1;
  logic [WORD_W-1:0] name_w2;
  logic [WORD_W-1:0] name_w3;
  logic [WORD_W-1:0] kind_w0;
  logic [WORD_W-1:0] kind_w1;
  logic [WORD_W-1:0] kind_w2;
  logic signed [QTY_W-1:0] quantity;

  modport source (output valid, mode, name_w0, name_w1, name_w2, name_w3,
                  kind_w0, kind_w1, kind_w2, quantity, input ready);
  modport sink (input valid, mode, name_w0, name_w1, name_w2, name_w3,
                kind_w0, kind_w1, kind_w2, quantity, output ready);
endinterface

// ===== src/kt_rsp_if.sv =====
// Response channel: status and reported entry.
interface kt_rsp_if
  import kt_pkg::*;
;
  logic              valid;
  logic              ready;
  status_t           status;
  logic [SLOT_W-1:0] slot;
  logic [WORD_W-1:0] entry_name_w0;
  logic [WORD_W-1:0] entry_name_w1;
  logic [WORD_W-1:0] entry_name_w2;
  logic [WORD_W-1:0] entry_name_w3;
  logic [WORD_W-1:0] entry_kind_w0;
  logic [WORD_W-1:0] entry_kind_w1;
  logic [WORD_W-1:0] entry_kind_w2;
  logic signed [QTY_W-1:0] entry_quantity;
  logic              last;

  modport source (output valid, status, slot, entry_name_w0, entry_name_w1,
                  entry_name_w2, entry_name_w3, entry_kind_w0, entry_kind_w1,
                  entry_kind_w2, entry_quantity, last, input ready);
  modport sink (input valid, status, slot, entry_name_w0, entry_name_w1,
                entry_name_w2, entry_name_w3, entry_kind_w0, entry_kind_w1,
                entry_kind_w2, entry_quantity, last, output ready);
endinterface

// ===== src/kt_canon.sv =====
// String normalizer: clears every byte after the first zero byte.
module kt_canon
  import kt_pkg::*;
#(
  parameter int WORDS = 4
) (
  input  logic [WORDS*WORD_W-1:0] raw,
  output logic [WORDS*WORD_W-1:0] canon
);

  localparam int NB = WORDS * 8;

  logic [NB-1:0] zero;
  logic [NB-1:0] first;
  logic [NB-1:0] after;

  // Zero flags in string order: byte 0 is the top byte of word 0
  always_comb begin
    for (int j = 0; j < NB; j++) begin
      zero[j] = (raw[(j / 8) * WORD_W + 56 - 8 * (j % 8) +: 8] == 8'd0);
    end
  end

  // Lowest set flag, then every position above it
  assign first = zero & (~zero + NB'(1));
  assign after = (~first + NB'(1)) & ~first;

  always_comb begin
    canon = raw;
    for (int j = 0; j < NB; j++) begin
      if (after[j]) begin
        canon[(j / 8) * WORD_W + 56 - 8 * (j % 8) +: 8] = 8'd0;
      end
    end
  end

endmodule

// ===== src/kt_cell.sv =====
// One table slot: holds an entry, compares its name, loads, takes a neighbor or the head.
module kt_cell
  import kt_pkg::*;
#(
  parameter int NAME_WORDS = 4,
  parameter int KIND_WORDS = 3
) (
  input  logic                         clk,
  input  cell_ctl_t                    ctl,
  input  logic [NAME_WORDS*WORD_W-1:0] key,
  input  logic [KIND_WORDS*WORD_W-1:0] load_kind,
  input  logic signed [QTY_W-1:0]      load_qty,
  input  logic [NAME_WORDS*WORD_W-1:0] nxt_name,
  input  logic [KIND_WORDS*WORD_W-1:0] nxt_kind,
  input  logic signed [QTY_W-1:0]      nxt_qty,
  input  logic [NAME_WORDS*WORD_W-1:0] head_name,
  input  logic [KIND_WORDS*WORD_W-1:0] head_kind,
  input  logic signed [QTY_W-1:0]      head_qty,
  output logic [NAME_WORDS*WORD_W-1:0] name,
  output logic [KIND_WORDS*WORD_W-1:0] kind,
  output logic signed [QTY_W-1:0]      qty,
  output logic                         hit
);

  // Entry storage: new entry, neighbor above, or wrapped head
  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      name <= key;
      kind <= load_kind;
      qty  <= load_qty;
    end else if (ctl.shift) begin
      name <= nxt_name;
      kind <= nxt_kind;
      qty  <= nxt_qty;
    end else if (ctl.wrap) begin
      name <= head_name;
      kind <= head_kind;
      qty  <= head_qty;
    end
  end

  assign hit = (name == key);

endmodule

// ===== src/keyed_table_with_compaction.sv =====
// Keyed table top level: control FSM, chain of entry cells, response register.
// Insert, remove, search: accept, parallel name compare in all cells, first-match select
// and shift, held while the response register is full; requests are taken only in idle.
// List: up to MAX_RESULTS results, one per cycle when the output is free, via cell rotation.
// Reset (rst, synchronous) clears the entry count, FSM and response valid; cells keep data.
module keyed_table_with_compaction
  import kt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int NAME_WORDS  = 4,
  parameter int KIND_WORDS  = 3
) (
  input logic clk,
  input logic rst,
  kt_req_if.sink   req,
  kt_rsp_if.source rsp
);

  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int IW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NB    = NAME_WORDS * WORD_W;
  localparam int KB    = KIND_WORDS * WORD_W;
  localparam int NPAD  = ((NAME_WORDS > NAME_IO) ? NAME_WORDS : NAME_IO) * WORD_W;
  localparam int KPAD  = ((KIND_WORDS > KIND_IO) ? KIND_WORDS : KIND_IO) * WORD_W;

  state_t state, state_next;

  logic [NB-1:0]           key_q;
  logic [KB-1:0]           kind_q;
  logic signed [QTY_W-1:0] qty_q;
  mode_t                   mode_q;
  logic [CW-1:0]           count, count_next;
  logic [CW-1:0]           lcnt, lcnt_next;
  logic [TABLE_DEPTH-1:0]  match_q;
  logic [TABLE_DEPTH-1:0]  vmask;
  logic [TABLE_DEPTH-1:0]  hit;
  logic [TABLE_DEPTH-1:0]  first;
  logic [TABLE_DEPTH-1:0]  at_or_above;
  logic [IW-1:0]           first_idx;
  logic [EXT_W-1:0]        count_ext;
  logic [EXT_W-1:0]        lcnt_ext;

  logic [NB-1:0] name_in;
  logic [KB-1:0] kind_in;
  logic [NB-1:0] name_canon;
  logic [KB-1:0] kind_canon;

  logic [NB-1:0]           cell_name [TABLE_DEPTH];
  logic [KB-1:0]           cell_kind [TABLE_DEPTH];
  logic signed [QTY_W-1:0] cell_qty  [TABLE_DEPTH];
  cell_ctl_t               ctl       [TABLE_DEPTH];

  logic [NB-1:0]           sel_name;
  logic [KB-1:0]           sel_kind;
  logic signed [QTY_W-1:0] sel_qty;

  // Response register
  logic                    rsp_valid;
  status_t                 out_status;
  logic [SLOT_W-1:0]       out_slot;
  logic [NB-1:0]           out_name;
  logic [KB-1:0]           out_kind;
  logic signed [QTY_W-1:0] out_qty;
  logic                    out_last;
  logic                    out_free;
  logic [NPAD-1:0]         out_name_pad;
  logic [KPAD-1:0]         out_kind_pad;

  logic                    emit;
  status_t                 e_status;
  logic [SLOT_W-1:0]       e_slot;
  logic [NB-1:0]           e_name;
  logic [KB-1:0]           e_kind;
  logic signed [QTY_W-1:0] e_qty;
  logic                    e_last;

  // Carrier words to table words; extra table words read as zero
  assign name_in = NB'(NPAD'({req.name_w3, req.name_w2, req.name_w1, req.name_w0}));
  assign kind_in = KB'(KPAD'({req.kind_w2, req.kind_w1, req.kind_w0}));

  kt_canon #(.WORDS(NAME_WORDS)) u_canon_name (.raw(name_in), .canon(name_canon));
  kt_canon #(.WORDS(KIND_WORDS)) u_canon_kind (.raw(kind_in), .canon(kind_canon));

  // Cell chain; the last cell's upper neighbor wraps to cell 0 and is taken only on remove
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    kt_cell #(
      .NAME_WORDS(NAME_WORDS),
      .KIND_WORDS(KIND_WORDS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .key       (key_q),
      .load_kind (kind_q),
      .load_qty  (qty_q),
      .nxt_name  (cell_name[(i + 1) % TABLE_DEPTH]),
      .nxt_kind  (cell_kind[(i + 1) % TABLE_DEPTH]),
      .nxt_qty   (cell_qty[(i + 1) % TABLE_DEPTH]),
      .head_name (cell_name[0]),
      .head_kind (cell_kind[0]),
      .head_qty  (cell_qty[0]),
      .name      (cell_name[i]),
      .kind      (cell_kind[i]),
      .qty       (cell_qty[i]),
      .hit       (hit[i])
    );
  end

  assign count_ext = EXT_W'(count);
  assign lcnt_ext  = EXT_W'(lcnt);

  // Occupied slots
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      vmask[i] = (EXT_W'(i) < count_ext);
    end
  end

  // First match as one-hot, and every slot from there up
  assign first       = match_q & (~match_q + TABLE_DEPTH'(1));
  assign at_or_above = ~first + TABLE_DEPTH'(1);

  // Encode and select the first matching entry
  always_comb begin
    first_idx = '0;
    sel_name  = '0;
    sel_kind  = '0;
    sel_qty   = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (first[i]) begin
        first_idx = first_idx | IW'(i);
        sel_name  = sel_name | cell_name[i];
        sel_kind  = sel_kind | cell_kind[i];
        sel_qty   = sel_qty | cell_qty[i];
      end
    end
  end

  assign out_free  = !rsp_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE);

  // Next state, cell control and response contents
  always_comb begin
    state_next = state;
    count_next = count;
    lcnt_next  = lcnt;
    emit       = 1'b0;
    e_status   = STAT_OK;
    e_slot     = '0;
    e_name     = '0;
    e_kind     = '0;
    e_qty      = '0;
    e_last     = 1'b1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      ctl[i] = '0;
    end

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_MATCH;
        end
      end
      ST_MATCH: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          unique case (mode_q)
            MODE_INSERT: begin
              emit       = 1'b1;
              state_next = ST_IDLE;
              if (count == CW'(TABLE_DEPTH)) begin
                e_status = STAT_FULL;
              end else begin
                e_slot     = SLOT_W'(count);
                e_name     = key_q;
                e_kind     = kind_q;
                e_qty      = qty_q;
                count_next = count + CW'(1);
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                  ctl[i].load = (EXT_W'(i) == count_ext);
                end
              end
            end
            MODE_LIST: begin
              if (count == '0) begin
                emit       = 1'b1;
                e_status   = STAT_EMPTY;
                state_next = ST_IDLE;
              end else begin
                lcnt_next  = '0;
                state_next = ST_LIST;
              end
            end
            MODE_REMOVE, MODE_SEARCH: begin
              emit       = 1'b1;
              state_next = ST_IDLE;
              if (count == '0) begin
                e_status = STAT_EMPTY;
              end else if (match_q == '0) begin
                e_status = STAT_NOT_FOUND;
              end else begin
                e_slot = SLOT_W'(first_idx);
                e_name = sel_name;
                e_kind = sel_kind;
                e_qty  = sel_qty;
                if (mode_q == MODE_REMOVE) begin
                  // compaction: every slot from the hit up takes its neighbor
                  count_next = count - CW'(1);
                  for (int i = 0; i < TABLE_DEPTH; i++) begin
                    ctl[i].shift = at_or_above[i];
                  end
                end
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_LIST: begin
        // rotate the occupied slots; slot 0 holds the entry being listed
        if ((lcnt_ext >= EXT_W'(MAX_RESULTS)) || out_free) begin
          emit      = (lcnt_ext < EXT_W'(MAX_RESULTS));
          e_slot    = SLOT_W'(lcnt);
          e_name    = cell_name[0];
          e_kind    = cell_kind[0];
          e_qty     = cell_qty[0];
          e_last    = (lcnt_ext + EXT_W'(1) == count_ext) ||
                      (lcnt_ext + EXT_W'(1) == EXT_W'(MAX_RESULTS));
          lcnt_next = lcnt + CW'(1);
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            ctl[i].shift = (EXT_W'(i + 1) < count_ext);
            ctl[i].wrap  = (EXT_W'(i + 1) == count_ext);
          end
          if (lcnt + CW'(1) == count) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      lcnt      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      lcnt  <= lcnt_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request capture, match vector and response payload
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      mode_q <= req.mode;
      key_q  <= name_canon;
      kind_q <= kind_canon;
      qty_q  <= req.quantity;
    end
    if (state == ST_MATCH) begin
      match_q <= hit & vmask;
    end
    if (emit) begin
      out_status <= e_status;
      out_slot   <= e_slot;
      out_name   <= e_name;
      out_kind   <= e_kind;
      out_qty    <= e_qty;
      out_last   <= e_last;
    end
  end

  assign out_name_pad = NPAD'(out_name);
  assign out_kind_pad = KPAD'(out_kind);

  assign rsp.valid          = rsp_valid;
  assign rsp.status         = out_status;
  assign rsp.slot           = out_slot;
  assign rsp.entry_name_w0  = out_name_pad[0*WORD_W +: WORD_W];
  assign rsp.entry_name_w1  = out_name_pad[1*WORD_W +: WORD_W];
  assign rsp.entry_name_w2  = out_name_pad[2*WORD_W +: WORD_W];
  assign rsp.entry_name_w3  = out_name_pad[3*WORD_W +: WORD_W];
  assign rsp.entry_kind_w0  = out_kind_pad[0*WORD_W +: WORD_W];
  assign rsp.entry_kind_w1  = out_kind_pad[1*WORD_W +: WORD_W];
  assign rsp.entry_kind_w2  = out_kind_pad[2*WORD_W +: WORD_W];
  assign rsp.entry_quantity = out_qty;
  assign rsp.last           = out_last;

endmodule
